/* rtl/core/imu_fp_pkg.sv */
// imu_fp_pkg: shared types and constants for the imu frame parser
// parse phase codes, protocol bytes and the result record
// no dependencies
package imu_fp_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h55;
  localparam logic [7:0] ATTITUDE_ID = 8'h01;
  localparam logic [23:0] YAW_SCALE  = 24'd180;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [15:0] yaw_degrees_q7;
    logic        is_attitude;
    logic [7:0]  frame_sum;
    logic [47:0] payload_bytes;
    logic [2:0]  frame_length;
    logic [7:0]  frame_id;
  } result_t;

endpackage

/* rtl/core/imu_fp_in_stage.sv */
// imu_fp_in_stage: input register for received bytes
// holds one byte until the parser takes it
// depends on nothing
module imu_fp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_tready  = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

endmodule

/* rtl/core/imu_fp_parser.sv */
// imu_fp_parser: frame state machine, payload buffer and yaw conversion
// one byte per fire, result record produced combinationally
// depends on imu_fp_pkg
module imu_fp_parser
  import imu_fp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int IW = $clog2(MAX_PAYLOAD);

  phase_t        phase_r, phase_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [LW-1:0] index_r, index_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [LW-1:0] length_r, length_nxt;
  logic [7:0]    store_r [MAX_PAYLOAD];
  logic [7:0]    store_nxt [MAX_PAYLOAD];
  logic [15:0]   yaw_r, yaw_nxt;

  logic [15:0]   raw;
  logic [23:0]   prod;
  logic [15:0]   yaw_new;
  logic          att;
  logic [LW-1:0] index_inc;

  assign raw       = {store_r[5], store_r[4]};
  assign prod      = {{8{raw[15]}}, raw} * YAW_SCALE;
  assign yaw_new   = prod[23:8];
  assign att       = (id_r == ATTITUDE_ID);
  assign index_inc = index_r + LW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      sum_r    <= '0;
      index_r  <= '0;
      id_r     <= '0;
      length_r <= '0;
      yaw_r    <= '0;
      for (int i = 0; i < MAX_PAYLOAD; i++) begin
        store_r[i] <= '0;
      end
    end else if (fire) begin
      phase_r  <= phase_nxt;
      sum_r    <= sum_nxt;
      index_r  <= index_nxt;
      id_r     <= id_nxt;
      length_r <= length_nxt;
      yaw_r    <= yaw_nxt;
      store_r  <= store_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    index_nxt  = index_r;
    id_nxt     = id_r;
    length_nxt = length_r;
    yaw_nxt    = yaw_r;
    store_nxt  = store_r;
    res_valid  = 1'b0;

    res.frame_id       = id_r;
    res.frame_length   = length_r[2:0];
    res.frame_sum      = rx_byte;
    res.is_attitude    = att;
    res.yaw_degrees_q7 = att ? yaw_new : yaw_r;
    for (int k = 0; k < 6; k++) begin
      res.payload_bytes[8*k +: 8] = store_r[k];
    end

    case (phase_r)
      PH_SYNC1: begin
        if (rx_byte == SYNC_BYTE) begin
          phase_nxt = PH_SYNC2;
        end
        sum_nxt = rx_byte;
      end
      PH_SYNC2: begin
        phase_nxt = (rx_byte == SYNC_BYTE) ? PH_ID : PH_SYNC1;
        sum_nxt   = sum_r + rx_byte;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        phase_nxt = PH_LEN;
        sum_nxt   = sum_r + rx_byte;
      end
      PH_LEN: begin
        if (rx_byte <= 8'(MAX_PAYLOAD)) begin
          length_nxt = rx_byte[LW-1:0];
          index_nxt  = '0;
          phase_nxt  = (rx_byte != 8'd0) ? PH_DATA : PH_SUM;
          sum_nxt    = sum_r + rx_byte;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_DATA: begin
        store_nxt[index_r[IW-1:0]] = rx_byte;
        index_nxt = index_inc;
        sum_nxt   = sum_r + rx_byte;
        if (index_inc >= length_r) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM: begin
        phase_nxt = PH_SYNC1;
        if (sum_r == rx_byte) begin
          res_valid = 1'b1;
          if (att) begin
            yaw_nxt = yaw_new;
          end
        end
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase
  end

  a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (index_r < length_r))
    else $error("payload index past frame length");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA || phase_r == PH_SUM) |-> (length_r <= LW'(MAX_PAYLOAD)))
    else $error("held length above maximum");

  a_emit_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (phase_r == PH_SUM && phase_nxt == PH_SYNC1))
    else $error("result outside checksum phase");

  a_yaw_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && !att) |=> ($past(yaw_r) == yaw_r))
    else $error("yaw changed on non attitude frame");

endmodule

/* rtl/core/imu_fp_out_reg.sv */
// imu_fp_out_reg: result register on the master side
// holds one frame record until the downstream transfer completes
// depends on imu_fp_pkg
module imu_fp_out_reg
  import imu_fp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  logic    load_valid,
  input  result_t load_data,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t data,
  output logic    can_load
);

  logic    valid_r;
  result_t data_r;

  assign out_tvalid = valid_r;
  assign data       = data_r;
  assign can_load   = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_valid;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule

/* rtl/core/imu_frame_parser_yaw_extract.sv */
// Frame parser for a sync / id / length / additive checksum byte stream with
// yaw extraction. One received byte is taken per transfer, and a byte can be
// taken in every cycle: it is held in the input register, passes the
// parser state machine and, when it is a matching checksum byte, lands in the
// result register, so the frame record follows the checksum byte through both
// registers. Throughput is one byte per cycle while the result side takes its
// transfers; a result that waits in the result register stalls every further
// byte in the input register until that result is taken. Frames with length
// above MAX_PAYLOAD or a bad checksum give no result. Yaw is raw * 180 / 256
// with floor, in degrees with 7 fraction bits.
// depends on imu_fp_pkg, imu_fp_in_stage, imu_fp_parser, imu_fp_out_reg
module imu_frame_parser_yaw_extract
  import imu_fp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_id, frame_length, payload_bytes, frame_sum, yaw_degrees_q7, zero pad
  output logic [87:0] out_tdata,
  output logic [0:0]  out_tuser   // is_attitude
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       can_load;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  assign fire = byte_valid && can_load;

  imu_fp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (fire),
    .byte_valid(byte_valid),
    .byte_data (byte_data)
  );

  imu_fp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .rx_byte  (byte_data),
    .res_valid(res_valid),
    .res      (res)
  );

  imu_fp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_valid(res_valid),
    .load_data (res),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .data      (out_data),
    .can_load  (can_load)
  );

  assign out_tdata = {5'd0, out_data.yaw_degrees_q7, out_data.frame_sum,
                      out_data.payload_bytes, out_data.frame_length,
                      out_data.frame_id};
  assign out_tuser = out_data.is_attitude;

endmodule

/* dv/tb_imu_frame_parser_yaw_extract.sv */
`timescale 1ns / 1ps
// tb_imu_frame_parser_yaw_extract: self-checking bench for the imu frame parser
// streams sync/id/length/checksum byte frames and checks every frame record
// depends on imu_fp_pkg and imu_frame_parser_yaw_extract
module tb_imu_frame_parser_yaw_extract;
  import imu_fp_pkg::*;

  localparam int MAX_LEN = 6;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [0:0]  out_tuser;

  rx_item_t rx_bytes_due[$];
  result_t  frame_records_due[$];

  int send_gap_pct = 7;
  int recv_stall_pct = 65;
  bit hold_request = 1'b0;
  bit hold_taken;
  int hold_left;
  int idle_cycles;
  int mismatches = 0;
  int bytes_queued = 0;

  // parser state as seen by the checker
  phase_t            cur_phase;
  logic [7:0]        sum_acc;
  int unsigned       pay_idx;
  logic [7:0]        frm_id;
  logic [2:0]        frm_len;
  logic [7:0]        pay_buf[MAX_LEN];
  logic signed [15:0] yaw_q7;

  imu_frame_parser_yaw_extract #(
    .MAX_PAYLOAD(MAX_LEN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  task automatic advance_parser(input logic [7:0] rx);
    result_t rec;
    logic signed [31:0] scaled;
    case (cur_phase)
      PH_SYNC1: begin
        if (rx == SYNC_BYTE) cur_phase = PH_SYNC2;
        sum_acc = rx;
      end
      PH_SYNC2: begin
        cur_phase = (rx == SYNC_BYTE) ? PH_ID : PH_SYNC1;
        sum_acc = sum_acc + rx;
      end
      PH_ID: begin
        frm_id = rx;
        cur_phase = PH_LEN;
        sum_acc = sum_acc + rx;
      end
      PH_LEN: begin
        if (rx <= MAX_LEN) begin
          frm_len = rx[2:0];
          pay_idx = 0;
          cur_phase = (rx != 0) ? PH_DATA : PH_SUM;
          sum_acc = sum_acc + rx;
        end else begin
          cur_phase = PH_SYNC1;
        end
      end
      PH_DATA: begin
        if (pay_idx < MAX_LEN) pay_buf[pay_idx] = rx;
        pay_idx++;
        sum_acc = sum_acc + rx;
        if (pay_idx >= frm_len) cur_phase = PH_SUM;
      end
      PH_SUM: begin
        cur_phase = PH_SYNC1;
        if (sum_acc == rx) begin
          rec.is_attitude = (frm_id == ATTITUDE_ID);
          if (rec.is_attitude) begin
            // raw is signed, yaw = floor(raw * 180 / 256)
            scaled = $signed({pay_buf[5], pay_buf[4]}) * 32'sd180;
            yaw_q7 = scaled[23:8];
          end
          rec.frame_id = frm_id;
          rec.frame_length = frm_len;
          for (int k = 0; k < 6; k++) rec.payload_bytes[8*k +: 8] = pay_buf[k];
          rec.frame_sum = rx;
          rec.yaw_degrees_q7 = yaw_q7;
          frame_records_due.push_back(rec);
        end
      end
      default: cur_phase = PH_SYNC1;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] data, input bit drain_first);
    rx_item_t item;
    item.data = data;
    item.drain_first = drain_first;
    rx_bytes_due.push_back(item);
    bytes_queued++;
  endtask

  task automatic push_frame(input logic [7:0] id, input logic [7:0] len_byte,
                            input logic [47:0] body, input bit corrupt_sum,
                            input bit drain_first);
    logic [7:0] sum;
    sum = SYNC_BYTE + SYNC_BYTE + id + len_byte;
    push_byte(SYNC_BYTE, drain_first);
    push_byte(SYNC_BYTE, 1'b0);
    push_byte(id, 1'b0);
    push_byte(len_byte, 1'b0);
    if (len_byte <= MAX_LEN) begin
      for (int k = 0; k < len_byte; k++) begin
        push_byte(body[8*k +: 8], 1'b0);
        sum = sum + body[8*k +: 8];
      end
      if (corrupt_sum) sum = sum + 8'($urandom_range(255, 1));
      push_byte(sum, 1'b0);
    end
  endtask

  task automatic push_random(input int target, input bit drain_once);
    int pick;
    logic [7:0] id;
    logic [47:0] body;
    bit drain;
    drain = drain_once;
    target = bytes_queued + target;
    while (bytes_queued < target) begin
      pick = $urandom_range(99);
      id = ($urandom_range(99) < 30) ? ATTITUDE_ID : 8'($urandom);
      body = {16'($urandom), 32'($urandom)};
      if ($urandom_range(9) == 0) body[47:32] = $urandom_range(1) ? 16'h7fff : 16'h8000;
      if (pick < 70) begin
        push_frame(id, 8'($urandom_range(MAX_LEN)), body, 1'b0, drain);
        drain = 1'b0;
      end else if (pick < 80) begin
        push_frame(id, 8'($urandom_range(MAX_LEN)), body, 1'b1, 1'b0);
      end else if (pick < 87) begin
        push_frame(id, 8'($urandom_range(255, MAX_LEN + 1)), body, 1'b0, 1'b0);
      end else if (pick < 93) begin
        push_byte(SYNC_BYTE, 1'b0);
        push_byte(8'($urandom_range(1) ? $urandom_range(8'h54) : $urandom_range(255, 8'h56)),
                  1'b0);
      end else begin
        push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic wait_sent;
    while (rx_bytes_due.size() != 0 || in_tvalid) @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      cur_phase = PH_SYNC1;
      sum_acc = '0;
      pay_idx = 0;
      frm_id = '0;
      frm_len = '0;
      for (int k = 0; k < MAX_LEN; k++) pay_buf[k] = '0;
      yaw_q7 = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_parser(in_tdata);
        void'(rx_bytes_due.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered byte
      end else if (rx_bytes_due.size() != 0 &&
                   !(rx_bytes_due[0].drain_first && frame_records_due.size() != 0) &&
                   $urandom_range(99) >= send_gap_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= rx_bytes_due[0].data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side ready, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      out_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_records_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame record: tdata=%h tuser=%b", out_tdata, out_tuser);
      end else begin
        want = frame_records_due.pop_front();
        if (out_tdata[7:0] !== want.frame_id || out_tdata[10:8] !== want.frame_length ||
            out_tdata[58:11] !== want.payload_bytes || out_tdata[66:59] !== want.frame_sum ||
            out_tdata[82:67] !== want.yaw_degrees_q7 || out_tuser[0] !== want.is_attitude) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"frame mismatch: exp id=%h len=%0d pay=%h sum=%h att=%b yaw=%h",
                      " / got id=%h len=%0d pay=%h sum=%h att=%b yaw=%h"},
                     want.frame_id, want.frame_length, want.payload_bytes, want.frame_sum,
                     want.is_attitude, want.yaw_degrees_q7,
                     out_tdata[7:0], out_tdata[10:8], out_tdata[58:11], out_tdata[66:59],
                     out_tuser[0], out_tdata[82:67]);
        end
      end
    end
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    // directed frames
    push_byte(8'h00, 1'b0);
    push_byte(SYNC_BYTE, 1'b0);
    push_byte(8'haa, 1'b0);
    push_frame(ATTITUDE_ID, 8'd0, '0, 1'b0, 1'b0);
    push_frame(8'h02, 8'd7, '0, 1'b0, 1'b0);
    push_frame(ATTITUDE_ID, 8'd6, 48'h8000_a5a5_5a5a, 1'b0, 1'b0);
    push_frame(8'hff, 8'd0, '0, 1'b1, 1'b0);
    push_random(340, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait_sent();
    send_gap_pct = 65;
    recv_stall_pct = 7;
    push_random(170, 1'b0);
    push_random(170, 1'b1);
    wait_sent();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    push_random(340, 1'b0);
    wait_sent();

    while (frame_records_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
